FILE: rtl/dtof_pkg.sv
// ----------------------------------------------------------------------------
// dtof_pkg: shared types and constants of the two-way ranging datapath
// Holds the payload structs of both channels and the fixed scale constants.
// ----------------------------------------------------------------------------
package dtof_pkg;

  // Input item: three local and three remote timestamps.
  typedef struct packed {
    logic [31:0] local_poll_rx;
    logic [31:0] local_reply_tx;
    logic [31:0] local_final_rx;
    logic [31:0] remote_poll_tx;
    logic [31:0] remote_reply_rx;
    logic [31:0] remote_final_tx;
  } dtof_in_t;

  // Result item.
  typedef struct packed {
    logic [31:0] flight_ticks;
    logic [15:0] range_cm;
    logic        range_error;
  } dtof_out_t;

  // Control flags that travel with an item down the divider chain.
  typedef struct packed {
    logic valid;
    logic err;
    logic ovf;
  } dtof_ctl_t;

  // Centimeters per tick with 32 fractional bits.
  localparam logic [31:0] CM_PER_TICK_Q32 = 32'd2014492935;
  localparam logic [31:0] TICKS_MAX       = 32'hFFFF_FFFF;
  localparam logic [15:0] RANGE_MAX       = 16'hFFFF;
  localparam int          QUOT_BITS       = 32;

endpackage

FILE: rtl/dtof_div_cell.sv
// ----------------------------------------------------------------------------
// dtof_div_cell: one restoring division step
// Shifts the next numerator bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the data word.
// ----------------------------------------------------------------------------
module dtof_div_cell #(
  parameter int SW = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  dtof_pkg::dtof_ctl_t  ctl_i,
  input  logic [SW-1:0]        rem_i,
  input  logic [31:0]          word_i,
  input  logic [SW-1:0]        div_i,
  output dtof_pkg::dtof_ctl_t  ctl_o,
  output logic [SW-1:0]        rem_o,
  output logic [31:0]          word_o,
  output logic [SW-1:0]        div_o
);
  import dtof_pkg::*;

  logic [SW:0]   trial;
  logic          fits;
  logic [SW-1:0] rem_d, rem_q;
  logic [31:0]   word_d, word_q;
  logic [SW-1:0] div_q;
  dtof_ctl_t     ctl_q;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial  = {rem_i, word_i[31]};
    fits   = trial >= {1'b0, div_i};
    rem_d  = fits ? SW'(trial - {1'b0, div_i}) : trial[SW-1:0];
    word_d = {word_i[30:0], fits};
  end

  // Control flags are reset; the data path is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      word_q <= word_d;
      div_q  <= div_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign word_o = word_q;
  assign div_o  = div_q;

endmodule

FILE: rtl/ds_twr_tof_distance_top.sv
// ----------------------------------------------------------------------------
// ds_twr_tof_distance_top: double-sided two-way ranging time of flight
// Forms the four exchange intervals and gives flight time and distance.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one ranging
// exchange of six timestamps per transfer. The output channel (out_valid_o,
// out_stall_i, out_data_o) gives flight time in ticks, range in centimeters
// and an error flag that is set when the interval sum is zero.
// The pipeline takes one item per cycle and gives one result per cycle
// while the receiver does not stall. Each item passes registered stages
// for the intervals, the split products, their recombination, their
// difference and the divider start, the chain of divider cells (one
// quotient bit per cell), the distance multiply and the saturation into
// the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o is raised for as long as the result waits, even when earlier
// stages hold bubbles. Without a stall one transfer moves every cycle.
// Reset clears the valid flags of every stage; no result is pending after
// reset.
// ----------------------------------------------------------------------------
module ds_twr_tof_distance_top #(
  parameter int STAMP_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dtof_pkg::dtof_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtof_pkg::dtof_out_t out_data_o
);
  import dtof_pkg::*;

  localparam int SB = STAMP_BITS;
  localparam int PW = 2 * SB;
  localparam int SW = SB + 2;
  localparam int H  = (SB + 1) / 2;

  logic en;
  logic out_valid_q;
  dtof_out_t out_q;

  // The pipeline moves unless a finished result is held by the receiver.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: intervals modulo 2^SB and their sum.
  logic          v1_q;
  logic [SB-1:0] lp, lr, lf, rp, rr, rf;
  logic [SB-1:0] reply1, reply2, round1, round2;
  logic [SB-1:0] t1_q [4];
  logic [SW-1:0] s1_q;

  assign lp = SB'(in_data_i.local_poll_rx);
  assign lr = SB'(in_data_i.local_reply_tx);
  assign lf = SB'(in_data_i.local_final_rx);
  assign rp = SB'(in_data_i.remote_poll_tx);
  assign rr = SB'(in_data_i.remote_reply_rx);
  assign rf = SB'(in_data_i.remote_final_tx);

  // Each interval wraps at the stamp width before it enters the sum.
  assign reply1 = lr - lp;
  assign reply2 = rf - rr;
  assign round1 = rr - rp;
  assign round2 = lf - lr;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q[0] <= reply1;
      t1_q[1] <= reply2;
      t1_q[2] <= round1;
      t1_q[3] <= round2;
      s1_q    <= SW'(reply1) + SW'(reply2) + SW'(round1) + SW'(round2);
    end
  end

  // Stage 2: each product split into four half-width partial products.
  logic            v2_q;
  logic [SW-1:0]   s2_q;
  logic [H-1:0]    ah [2], al [2], bh [2], bl [2];
  logic [2*H-1:0]  pp_q [8];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      al[k] = t1_q[2*k][H-1:0];
      ah[k] = H'(t1_q[2*k] >> H);
      bl[k] = t1_q[2*k+1][H-1:0];
      bh[k] = H'(t1_q[2*k+1] >> H);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s1_q;
      for (int k = 0; k < 2; k++) begin
        pp_q[4*k]   <= al[k] * bl[k];
        pp_q[4*k+1] <= ah[k] * bl[k];
        pp_q[4*k+2] <= al[k] * bh[k];
        pp_q[4*k+3] <= ah[k] * bh[k];
      end
    end
  end

  // Stage 3: recombine the partial products.
  logic          v3_q;
  logic [SW-1:0] s3_q;
  logic [PW-1:0] prod_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s2_q;
      for (int k = 0; k < 2; k++) begin
        prod_q[k] <= PW'(pp_q[4*k]) + (PW'(pp_q[4*k+1]) << H)
                   + (PW'(pp_q[4*k+2]) << H) + (PW'(pp_q[4*k+3]) << (2 * H));
      end
    end
  end

  // Stage 4: magnitude of the product difference.
  logic          v4_q;
  logic [SW-1:0] s4_q;
  logic [PW-1:0] diff_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q   <= s3_q;
      diff_q <= (prod_q[0] >= prod_q[1]) ? prod_q[0] - prod_q[1]
                                         : prod_q[1] - prod_q[0];
    end
  end

  // Stage 5: overflow check and divider start. When the quotient fits in
  // 32 bits the upper numerator part is below the divisor.
  logic [PW-1:0] num_hi;
  dtof_ctl_t     c5_q;
  logic [SW-1:0] r5_q, d5_q;
  logic [31:0]   w5_q;

  assign num_hi = PW'({32'd0, diff_q} >> 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      c5_q <= '0;
    end else if (en) begin
      v1_q       <= in_valid_i;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      c5_q.valid <= v4_q;
      c5_q.err   <= s4_q == '0;
      c5_q.ovf   <= num_hi >= PW'(s4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r5_q <= num_hi[SW-1:0];
      w5_q <= diff_q[31:0];
      d5_q <= s4_q;
    end
  end

  // Chain of divider cells, one quotient bit per cell.
  dtof_ctl_t     cc [QUOT_BITS+1];
  logic [SW-1:0] cr [QUOT_BITS+1];
  logic [31:0]   cw [QUOT_BITS+1];
  logic [SW-1:0] cd [QUOT_BITS+1];

  assign cc[0] = c5_q;
  assign cr[0] = r5_q;
  assign cw[0] = w5_q;
  assign cd[0] = d5_q;

  for (genvar g = 0; g < QUOT_BITS; g++) begin : g_cell
    dtof_div_cell #(.SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (cc[g]),
      .rem_i  (cr[g]),
      .word_i (cw[g]),
      .div_i  (cd[g]),
      .ctl_o  (cc[g+1]),
      .rem_o  (cr[g+1]),
      .word_o (cw[g+1]),
      .div_o  (cd[g+1])
    );
  end

  // Distance multiply on the final tick count.
  logic        vm_q;
  logic        em_q;
  logic [31:0] ticks, tm_q;
  logic [63:0] cmp_q;

  always_comb begin
    if (cc[QUOT_BITS].err) begin
      ticks = '0;
    end else if (cc[QUOT_BITS].ovf) begin
      ticks = TICKS_MAX;
    end else begin
      ticks = cw[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tm_q  <= ticks;
      em_q  <= cc[QUOT_BITS].err;
      cmp_q <= 64'(ticks) * 64'(CM_PER_TICK_Q32);
    end
  end

  // Saturation into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vm_q        <= cc[QUOT_BITS].valid;
      out_valid_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.flight_ticks <= tm_q;
      out_q.range_cm     <= (cmp_q[63:48] != '0) ? RANGE_MAX : cmp_q[47:32];
      out_q.range_error  <= em_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sim/ds_twr_tof_distance_top_test.sv
// ----------------------------------------------------------------------------
// ds_twr_tof_distance_top_test: ranging datapath testbench
// Drives ranging exchanges, predicts flight time, range and the error flag
// in integer arithmetic, and checks every result in order under idling,
// receiver stalls and long back-pressure.
`timescale 1ns / 1ps

module ds_twr_tof_distance_top_test;
  import dtof_pkg::*;

  localparam int LATENCY = 39;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  dtof_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  dtof_out_t out_data_o;

  dtof_out_t range_q[$];
  int        fail_count;
  int        sent_count;
  int        checked_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_off;
  int        hold_cycles;

  ds_twr_tof_distance_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Exact time of flight from one exchange, as the block must compute it.
  function automatic dtof_out_t predict_range(dtof_in_t x);
    logic [31:0]  treply1, tround2, tround1, treply2;
    logic [33:0]  sum;
    logic [63:0]  pa, pb, diff;
    logic [63:0]  quot;
    logic [63:0]  cm;
    dtof_out_t    r;
    treply1 = x.local_reply_tx - x.local_poll_rx;
    tround2 = x.local_final_rx - x.local_reply_tx;
    tround1 = x.remote_reply_rx - x.remote_poll_tx;
    treply2 = x.remote_final_tx - x.remote_reply_rx;
    sum = {2'b0, treply1} + {2'b0, treply2} + {2'b0, tround1} + {2'b0, tround2};
    r = '0;
    if (sum == 0) begin
      r.range_error = 1'b1;
      return r;
    end
    pa = {32'b0, treply1} * {32'b0, treply2};
    pb = {32'b0, tround1} * {32'b0, tround2};
    diff = (pa < pb) ? pb - pa : pa - pb;
    quot = diff / {30'b0, sum};
    r.flight_ticks = (quot > {32'b0, TICKS_MAX}) ? TICKS_MAX : quot[31:0];
    cm = ({32'b0, r.flight_ticks} * {32'b0, CM_PER_TICK_Q32}) >> 32;
    r.range_cm = (cm > {48'b0, RANGE_MAX}) ? RANGE_MAX : cm[15:0];
    return r;
  endfunction

  // Offer one exchange and hold it until the transfer happens. Valid stays
  // high between exchanges unless the sender idles.
  task automatic send_exchange(dtof_in_t x);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
    range_q.push_back(predict_range(x));
    sent_count++;
    @(negedge clk_i);
  endtask

  // Receiver stall, with a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_off && hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    dtof_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (range_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = range_q.pop_front();
        checked_count++;
        if (want.flight_ticks !== out_data_o.flight_ticks)
          $display("%0t: flight_ticks expected %h actual %h", $time,
                   want.flight_ticks, out_data_o.flight_ticks);
        if (want.range_cm !== out_data_o.range_cm)
          $display("%0t: range_cm expected %h actual %h", $time,
                   want.range_cm, out_data_o.range_cm);
        if (want.range_error !== out_data_o.range_error)
          $display("%0t: range_error expected %b actual %b", $time,
                   want.range_error, out_data_o.range_error);
        if (want !== out_data_o) fail_count++;
      end
    end
  end

  // Build an exchange from two start stamps and four intervals.
  function automatic dtof_in_t make_exchange(logic [31:0] lp, logic [31:0] rp,
                                             logic [31:0] r1, logic [31:0] d2,
                                             logic [31:0] d1, logic [31:0] r2);
    dtof_in_t x;
    x.local_poll_rx   = lp;
    x.local_reply_tx  = lp + r1;
    x.local_final_rx  = lp + r1 + d2;
    x.remote_poll_tx  = rp;
    x.remote_reply_rx = rp + d1;
    x.remote_final_tx = rp + d1 + r2;
    return x;
  endfunction

  function automatic logic [31:0] rand_interval();
    case ($urandom_range(3))
      0: return $urandom_range(200000);
      1: return $urandom;
      2: return $urandom_range(20000000, 1000000);
      default: return 32'hFFFF_FFFF - $urandom_range(3);
    endcase
  endfunction

  // A random exchange: mostly round trips of replies plus twice the flight, else random stamps.
  function automatic dtof_in_t rand_exchange();
    logic [31:0] r1, r2, tof;
    dtof_in_t    x;
    if ($urandom_range(9) < 2) begin
      x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return x;
    end
    r1  = rand_interval();
    r2  = rand_interval();
    tof = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300000);
    return make_exchange($urandom, $urandom, r1, r2 + 2 * tof, r2 * 0 + r1 + 2 * tof,
                         r2);
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (range_q.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  // Directed corners: zero sum, wrap, saturation, bit extremes.
  task automatic test_directed();
    dtof_in_t x;
    send_exchange('0);
    send_exchange('1);
    send_exchange(make_exchange(32'hFFFF_FFF0, 32'h0, 0, 0, 0, 0));
    send_exchange(make_exchange(32'hFFFF_FF00, 32'hFFFF_FFFF, 1000, 1200, 1200, 1000));
    send_exchange(make_exchange(0, 0, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF));
    send_exchange(make_exchange(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    send_exchange(make_exchange(5, 7, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF));
    send_exchange(make_exchange(0, 0, 1, 0, 0, 0));
    send_exchange(make_exchange(0, 0, 1000, 1400, 1400, 1000));
    send_exchange(make_exchange(0, 0, 100, 100 + 2 * 139722, 100 + 2 * 139722, 100));
    send_exchange(make_exchange(0, 0, 100, 100 + 2 * 139723, 100 + 2 * 139723, 100));
    x = {6{32'hAAAA_AAAA}};
    send_exchange(x);
    x = {6{32'h5555_5555}};
    send_exchange(x);
    x = {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    send_exchange(x);
    x = {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
    send_exchange(x);
    wait_drained();
  endtask

  // Random exchanges under one idling profile.
  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_exchange(rand_exchange());
    wait_drained();
  endtask

  // Receiver holds off long enough for the pipeline to fill and back up.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_cycles = 200;
    hold_off    = 1'b1;
    repeat (120) send_exchange(rand_exchange());
    hold_off = 1'b0;
    wait_drained();
  endtask

  initial begin
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    fail_count     = 0;
    sent_count     = 0;
    checked_count  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b0;
    hold_cycles    = 0;
    rst_ni         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500, 0, 0);
    test_random(400, 72, 0);
    test_random(400, 0, 72);
    test_random(400, 29, 29);
    test_backpressure();
    test_random(130, 0, 0);
    $display("Sent %0d ranging exchanges, checked %0d results across", sent_count,
             checked_count);
    $display("idle, stall and long back-pressure phases.");
    if (fail_count == 0 && range_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
